@@ design/dimu_pkg.sv @@
// shared types, widths and a saturating add helper for the dual imu integrator
// no dependencies; used by dimu_ctrl, dimu_dpath and the top level
package dimu_pkg;

    // sample and interval widths
    localparam int SAMPLE_BITS   = 16;
    localparam int INTERVAL_BITS = 16;

    // accumulator width and derived datapath widths
    localparam int ACC_W    = 64;
    localparam int HALF_W   = ACC_W / 2;
    localparam int SUM_W    = SAMPLE_BITS + 1;
    localparam int TOT_W    = SUM_W + 1;
    localparam int ANET_W   = SAMPLE_BITS + 3;
    localparam int MUL_A_W  = HALF_W + 1;
    localparam int MUL_B_W  = INTERVAL_BITS + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int LO_W     = HALF_W + INTERVAL_BITS;
    localparam int FULL_W   = PROD_W + HALF_W;

    // axes
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 2'd2;

    // saturation limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // input beat
    typedef struct packed {
        logic                            sensor_id;
        logic signed [SAMPLE_BITS-1:0]   accel_x;
        logic signed [SAMPLE_BITS-1:0]   accel_y;
        logic signed [SAMPLE_BITS-1:0]   accel_z;
        logic signed [SAMPLE_BITS-1:0]   rate_x;
        logic signed [SAMPLE_BITS-1:0]   rate_y;
        logic signed [SAMPLE_BITS-1:0]   rate_z;
        logic        [INTERVAL_BITS-1:0] interval_us;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic signed [ACC_W-1:0] rotation_x;
        logic signed [ACC_W-1:0] rotation_y;
        logic signed [ACC_W-1:0] rotation_z;
        logic signed [ACC_W-1:0] velocity_x;
        logic signed [ACC_W-1:0] velocity_y;
        logic signed [ACC_W-1:0] velocity_z;
        logic signed [ACC_W-1:0] position_x;
        logic signed [ACC_W-1:0] position_y;
        logic signed [ACC_W-1:0] position_z;
    } t_out_beat;

    // datapath step codes
    typedef enum logic [3:0] {
        DP_NONE    = 4'd0,
        DP_MUL_ROT = 4'd1,
        DP_ROT_ACC = 4'd2,
        DP_ADD_VEL = 4'd3,
        DP_SUM_V   = 4'd4,
        DP_MUL_LO  = 4'd5,
        DP_MUL_HI  = 4'd6,
        DP_SAT_P   = 4'd7,
        DP_ADD_POS = 4'd8
    } t_dp_op;

    // controller to datapath command
    typedef struct packed {
        t_dp_op              op;
        logic [AXIS_W-1:0]   axis;
        logic                load_a;
        logic                load_prime;
        logic                load_pair;
        logic                load_out;
    } t_dp_cmd;

    // signed add clamped to the accumulator range
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

@@ design/dimu_ctrl.sv @@
// sequencer for the dual imu integrator: handshakes, priming and step order
// depends on dimu_pkg; drives dimu_dpath through a command struct
module dimu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_sensor_id,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output dimu_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_MUL_ROT = 10'b00_0000_0010,
        S_ROT_ACC = 10'b00_0000_0100,
        S_ADD_VEL = 10'b00_0000_1000,
        S_SUM_V   = 10'b00_0001_0000,
        S_MUL_LO  = 10'b00_0010_0000,
        S_MUL_HI  = 10'b00_0100_0000,
        S_SAT_P   = 10'b00_1000_0000,
        S_ADD_POS = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic [dimu_pkg::AXIS_W-1:0]   r_axis, n_axis;
    logic                          r_primed, n_primed;
    logic                          r_out_valid, n_out_valid;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_primed    = r_primed;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.op    = dimu_pkg::DP_NONE;
        o_cmd.axis  = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_sensor_id) begin
                        o_cmd.load_a = 1'b1;
                    end else if (!r_primed) begin
                        o_cmd.load_prime = 1'b1;
                        n_primed         = 1'b1;
                    end else begin
                        o_cmd.load_pair = 1'b1;
                        n_axis          = '0;
                        n_state         = S_MUL_ROT;
                    end
                end
            end
            S_MUL_ROT: begin
                o_cmd.op = dimu_pkg::DP_MUL_ROT;
                n_state  = S_ROT_ACC;
            end
            S_ROT_ACC: begin
                o_cmd.op = dimu_pkg::DP_ROT_ACC;
                n_state  = S_ADD_VEL;
            end
            S_ADD_VEL: begin
                o_cmd.op = dimu_pkg::DP_ADD_VEL;
                n_state  = S_SUM_V;
            end
            S_SUM_V: begin
                o_cmd.op = dimu_pkg::DP_SUM_V;
                n_state  = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.op = dimu_pkg::DP_MUL_LO;
                n_state  = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.op = dimu_pkg::DP_MUL_HI;
                n_state  = S_SAT_P;
            end
            S_SAT_P: begin
                o_cmd.op = dimu_pkg::DP_SAT_P;
                n_state  = S_ADD_POS;
            end
            S_ADD_POS: begin
                o_cmd.op = dimu_pkg::DP_ADD_POS;
                if (r_axis == dimu_pkg::AXIS_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_MUL_ROT;
                end
            end
            S_DONE: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ design/dimu_dpath.sv @@
// datapath for the dual imu integrator: held samples, pair sums, shared
// multiplier, saturating accumulators and result register; uses dimu_pkg
module dimu_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dimu_pkg::t_dp_cmd                   i_cmd,
    input  dimu_pkg::t_in_beat                  i_in_data,
    input  logic                                i_cfg_we,
    input  logic [dimu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dimu_pkg::SAMPLE_BITS-1:0]    i_cfg_wdata,
    output dimu_pkg::t_out_beat                 o_out_data
);

    localparam int SB = dimu_pkg::SAMPLE_BITS;
    localparam int SW = dimu_pkg::SUM_W;
    localparam int AW = dimu_pkg::ACC_W;
    localparam int HW = dimu_pkg::HALF_W;

    // architectural state
    logic signed [SB-1:0] r_off         [dimu_pkg::NUM_AXES];
    logic signed [SB-1:0] r_held_accel  [dimu_pkg::NUM_AXES];
    logic signed [SB-1:0] r_held_rate   [dimu_pkg::NUM_AXES];
    logic signed [SW-1:0] r_prior_asum  [dimu_pkg::NUM_AXES];
    logic signed [SW-1:0] r_prior_rsum  [dimu_pkg::NUM_AXES];
    logic signed [AW-1:0] r_rot         [dimu_pkg::NUM_AXES];
    logic signed [AW-1:0] r_vel         [dimu_pkg::NUM_AXES];
    logic signed [AW-1:0] r_pos         [dimu_pkg::NUM_AXES];

    // working registers for the pair being integrated
    logic signed [SW-1:0]                    r_cur_asum [dimu_pkg::NUM_AXES];
    logic signed [SW-1:0]                    r_cur_rsum [dimu_pkg::NUM_AXES];
    logic [dimu_pkg::INTERVAL_BITS-1:0]      r_dt;
    logic signed [dimu_pkg::PROD_W-1:0]      r_prod;
    logic [dimu_pkg::LO_W-1:0]               r_plo;
    logic signed [AW-1:0]                    r_vold;
    logic signed [AW-1:0]                    r_s;
    logic signed [AW-1:0]                    r_pinc;
    dimu_pkg::t_out_beat                     r_out;

    logic signed [SB-1:0]                    w_in_accel [dimu_pkg::NUM_AXES];
    logic signed [SB-1:0]                    w_in_rate  [dimu_pkg::NUM_AXES];
    logic signed [SW-1:0]                    w_asum     [dimu_pkg::NUM_AXES];
    logic signed [SW-1:0]                    w_rsum     [dimu_pkg::NUM_AXES];
    logic signed [dimu_pkg::TOT_W-1:0]       w_rate_tot;
    logic signed [dimu_pkg::ANET_W-1:0]      w_acc_net;
    logic signed [dimu_pkg::MUL_A_W-1:0]     w_mul_a;
    logic signed [dimu_pkg::MUL_B_W-1:0]     w_mul_b;
    logic signed [dimu_pkg::PROD_W-1:0]      w_prod;
    logic signed [dimu_pkg::FULL_W-1:0]      w_full;
    logic signed [AW-1:0]                    w_full_sat;
    logic [dimu_pkg::AXIS_W-1:0]             w_ax;

    assign w_ax = i_cmd.axis;

    // unpack the input beat per axis and form the pair sums
    assign w_in_accel[0] = i_in_data.accel_x;
    assign w_in_accel[1] = i_in_data.accel_y;
    assign w_in_accel[2] = i_in_data.accel_z;
    assign w_in_rate[0]  = i_in_data.rate_x;
    assign w_in_rate[1]  = i_in_data.rate_y;
    assign w_in_rate[2]  = i_in_data.rate_z;

    always_comb begin
        for (int i = 0; i < dimu_pkg::NUM_AXES; i++) begin
            w_asum[i] = SW'(r_held_accel[i]) + SW'(w_in_accel[i]);
            w_rsum[i] = SW'(r_held_rate[i]) + SW'(w_in_rate[i]);
        end
    end

    // trapezoid numerators for the current axis
    assign w_rate_tot = dimu_pkg::TOT_W'(r_prior_rsum[w_ax])
                      + dimu_pkg::TOT_W'(r_cur_rsum[w_ax]);
    assign w_acc_net  = dimu_pkg::ANET_W'(r_prior_asum[w_ax])
                      + dimu_pkg::ANET_W'(r_cur_asum[w_ax])
                      - dimu_pkg::ANET_W'($signed({r_off[w_ax], 2'b00}));

    // shared multiplier operand select
    always_comb begin
        unique case (i_cmd.op)
            dimu_pkg::DP_MUL_ROT: w_mul_a = dimu_pkg::MUL_A_W'(w_rate_tot);
            dimu_pkg::DP_ROT_ACC: w_mul_a = dimu_pkg::MUL_A_W'(w_acc_net);
            dimu_pkg::DP_MUL_LO:  w_mul_a = $signed({1'b0, r_s[HW-1:0]});
            dimu_pkg::DP_MUL_HI:  w_mul_a = $signed({r_s[AW-1], r_s[AW-1:HW]});
            default:              w_mul_a = '0;
        endcase
    end

    assign w_mul_b = $signed({1'b0, r_dt});
    assign w_prod  = w_mul_a * w_mul_b;

    // recombine the two partial products of position and clamp
    assign w_full = $signed({r_prod, {HW{1'b0}}})
                  + $signed({{(dimu_pkg::FULL_W - dimu_pkg::LO_W){1'b0}}, r_plo});

    always_comb begin
        if (w_full > dimu_pkg::FULL_W'(dimu_pkg::ACC_MAX)) begin
            w_full_sat = dimu_pkg::ACC_MAX;
        end else if (w_full < dimu_pkg::FULL_W'(dimu_pkg::ACC_MIN)) begin
            w_full_sat = dimu_pkg::ACC_MIN;
        end else begin
            w_full_sat = w_full[AW-1:0];
        end
    end

    // offsets, held samples, history and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dimu_pkg::NUM_AXES; i++) begin
                r_off[i]        <= '0;
                r_held_accel[i] <= '0;
                r_held_rate[i]  <= '0;
                r_prior_asum[i] <= '0;
                r_prior_rsum[i] <= '0;
                r_rot[i]        <= '0;
                r_vel[i]        <= '0;
                r_pos[i]        <= '0;
            end
        end else begin
            // offset register writes, unused index ignored
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dimu_pkg::CFG_OFFSET_X: r_off[0] <= i_cfg_wdata;
                    dimu_pkg::CFG_OFFSET_Y: r_off[1] <= i_cfg_wdata;
                    dimu_pkg::CFG_OFFSET_Z: r_off[2] <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // sensor a beat is held until the next sensor a beat replaces it
            if (i_cmd.load_a) begin
                for (int i = 0; i < dimu_pkg::NUM_AXES; i++) begin
                    r_held_accel[i] <= w_in_accel[i];
                    r_held_rate[i]  <= w_in_rate[i];
                end
            end
            // first pair only seeds the history
            if (i_cmd.load_prime) begin
                for (int i = 0; i < dimu_pkg::NUM_AXES; i++) begin
                    r_prior_asum[i] <= w_asum[i];
                    r_prior_rsum[i] <= w_rsum[i];
                end
            end
            unique case (i_cmd.op)
                dimu_pkg::DP_ROT_ACC: begin
                    r_rot[w_ax] <= dimu_pkg::sat_add(r_rot[w_ax], AW'(r_prod));
                end
                dimu_pkg::DP_ADD_VEL: begin
                    r_vel[w_ax] <= dimu_pkg::sat_add(r_vel[w_ax], AW'(r_prod));
                end
                dimu_pkg::DP_ADD_POS: begin
                    r_pos[w_ax]        <= dimu_pkg::sat_add(r_pos[w_ax], r_pinc);
                    r_prior_asum[w_ax] <= r_cur_asum[w_ax];
                    r_prior_rsum[w_ax] <= r_cur_rsum[w_ax];
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pair) begin
            for (int i = 0; i < dimu_pkg::NUM_AXES; i++) begin
                r_cur_asum[i] <= w_asum[i];
                r_cur_rsum[i] <= w_rsum[i];
            end
            r_dt <= i_in_data.interval_us;
        end
        unique case (i_cmd.op)
            dimu_pkg::DP_MUL_ROT: r_prod <= w_prod;
            dimu_pkg::DP_ROT_ACC: r_prod <= w_prod;
            dimu_pkg::DP_ADD_VEL: r_vold <= r_vel[w_ax];
            dimu_pkg::DP_SUM_V:   r_s    <= dimu_pkg::sat_add(r_vold, r_vel[w_ax]);
            dimu_pkg::DP_MUL_LO:  r_plo  <= w_prod[dimu_pkg::LO_W-1:0];
            dimu_pkg::DP_MUL_HI:  r_prod <= w_prod;
            dimu_pkg::DP_SAT_P:   r_pinc <= w_full_sat;
            default: ;
        endcase
        // result register
        if (i_cmd.load_out) begin
            r_out.rotation_x <= r_rot[0];
            r_out.rotation_y <= r_rot[1];
            r_out.rotation_z <= r_rot[2];
            r_out.velocity_x <= r_vel[0];
            r_out.velocity_y <= r_vel[1];
            r_out.velocity_z <= r_vel[2];
            r_out.position_x <= r_pos[0];
            r_out.position_y <= r_pos[1];
            r_out.position_z <= r_pos[2];
        end
    end

    assign o_out_data = r_out;

endmodule

@@ design/dual_imu_trapezoid_integrator_top.sv @@
// Dual IMU trapezoidal integrator. Beats arrive as sensor A then sensor B; a
// sensor A beat is only held and leaves the block ready, as does the first B
// beat after reset, which only seeds the pair history. Every later B beat
// produces one result beat with rotation, velocity and position per axis,
// saturated at the signed 64-bit limits. Such a pair runs eight steps per
// axis through the one shared 33 by 17 bit multiplier and its saturating
// adders, then loads the result register, before the next beat can be taken.
// The result register lets the next beats be taken while a result waits; a
// finished pair waits only if the previous result has not yet been taken.
// The user must write offsets through the plain write port only while the
// block is idle; the block itself does not enforce this.
// top level; depends on dimu_pkg, dimu_ctrl and dimu_dpath
module dual_imu_trapezoid_integrator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  dimu_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output dimu_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [dimu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dimu_pkg::SAMPLE_BITS-1:0] i_cfg_wdata
);

    dimu_pkg::t_dp_cmd w_cmd;

    // sequencer
    dimu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_sensor_id (i_in_data.sensor_id),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    dimu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // a new result only appears after the sequencer loaded it
    a_rise_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("result valid rose without a result load");

    // no beat is taken while a pair is being integrated
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op != dimu_pkg::DP_NONE) |-> !o_in_ready)
        else $error("input ready while datapath busy");

    // the result register is never overwritten while a result waits
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    // pair loading only happens on an accepted sensor B beat
    a_pair_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_pair |-> (i_in_valid && o_in_ready && i_in_data.sensor_id))
        else $error("pair load without an accepted sensor B beat");
`endif

endmodule

@@ sim/dual_imu_trapezoid_integrator_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for dual_imu_trapezoid_integrator_top: a local
// integrator predicts every result beat; depends on dimu_pkg and the top level
module dual_imu_trapezoid_integrator_top_tb;

    // spare register index, writes to it must be ignored
    localparam logic [dimu_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int NAV_FIELDS  = 9;
    localparam int MAX_REPORTS = 10;
    // about 800 beats; even under the longest stalls this limit is ample
    localparam int CYCLE_LIMIT = 1000000;
    // leave some margin after the last result
    localparam int SETTLE_CYCLES = 40;

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_ready;
    dimu_pkg::t_in_beat               i_in_data   = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    dimu_pkg::t_out_beat              o_out_data;
    logic                             i_cfg_we    = 1'b0;
    logic [dimu_pkg::CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [dimu_pkg::SAMPLE_BITS-1:0] i_cfg_wdata = '0;

    // beats waiting to be sent and result beats waiting to arrive
    dimu_pkg::t_in_beat  imu_beats_pending [$];
    dimu_pkg::t_out_beat nav_expected [$];

    int   nav_mismatches = 0;
    int   cycle_count    = 0;
    bit   idle_on        = 1'b1;
    logic in_fire_q      = 1'b0;
    int   send_gap       = 0;
    int   stall_left     = 0;

    // local copy of the integrator state
    logic signed [dimu_pkg::SAMPLE_BITS-1:0] bias      [dimu_pkg::NUM_AXES] = '{default: '0};
    logic signed [dimu_pkg::SAMPLE_BITS-1:0] held_acc  [dimu_pkg::NUM_AXES] = '{default: '0};
    logic signed [dimu_pkg::SAMPLE_BITS-1:0] held_gyro [dimu_pkg::NUM_AXES] = '{default: '0};
    int                            last_acc_pair  [dimu_pkg::NUM_AXES] = '{default: 0};
    int                            last_gyro_pair [dimu_pkg::NUM_AXES] = '{default: 0};
    logic signed [dimu_pkg::ACC_W-1:0] rot_acc [dimu_pkg::NUM_AXES] = '{default: '0};
    logic signed [dimu_pkg::ACC_W-1:0] vel_acc [dimu_pkg::NUM_AXES] = '{default: '0};
    logic signed [dimu_pkg::ACC_W-1:0] pos_acc [dimu_pkg::NUM_AXES] = '{default: '0};
    bit                            have_history = 1'b0;

    dual_imu_trapezoid_integrator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // clamp an exact value to the signed 64-bit range
    function automatic logic signed [dimu_pkg::ACC_W-1:0] clamp64(
        input logic signed [127:0] v
    );
        if (v > dimu_pkg::ACC_MAX) return dimu_pkg::ACC_MAX;
        if (v < dimu_pkg::ACC_MIN) return dimu_pkg::ACC_MIN;
        return v[dimu_pkg::ACC_W-1:0];
    endfunction

    // apply one accepted beat and queue the result beat it causes, if any
    task automatic integrate_beat(input dimu_pkg::t_in_beat b);
        logic signed [dimu_pkg::SAMPLE_BITS-1:0] acc_in  [dimu_pkg::NUM_AXES];
        logic signed [dimu_pkg::SAMPLE_BITS-1:0] gyro_in [dimu_pkg::NUM_AXES];
        logic signed [127:0]           dt, wide, v_old, v_new, pos_step;
        int                            acc_pair, gyro_pair, acc_net;
        dimu_pkg::t_out_beat           nav;
        acc_in[0]  = b.accel_x;
        acc_in[1]  = b.accel_y;
        acc_in[2]  = b.accel_z;
        gyro_in[0] = b.rate_x;
        gyro_in[1] = b.rate_y;
        gyro_in[2] = b.rate_z;
        if (!b.sensor_id) begin
            // sensor A: hold the reading, latest one wins
            for (int i = 0; i < dimu_pkg::NUM_AXES; i++) begin
                held_acc[i]  = acc_in[i];
                held_gyro[i] = gyro_in[i];
            end
        end else if (!have_history) begin
            // first pair only seeds the history
            for (int i = 0; i < dimu_pkg::NUM_AXES; i++) begin
                last_acc_pair[i]  = held_acc[i] + acc_in[i];
                last_gyro_pair[i] = held_gyro[i] + gyro_in[i];
            end
            have_history = 1'b1;
        end else begin
            dt = b.interval_us;
            for (int i = 0; i < dimu_pkg::NUM_AXES; i++) begin
                acc_pair  = held_acc[i] + acc_in[i];
                gyro_pair = held_gyro[i] + gyro_in[i];
                acc_net   = last_acc_pair[i] + acc_pair - 4 * bias[i];
                // trapezoid step for rotation
                wide       = last_gyro_pair[i] + gyro_pair;
                wide       = rot_acc[i] + wide * dt;
                rot_acc[i] = clamp64(wide);
                // velocity, offset removed
                v_old      = vel_acc[i];
                wide       = acc_net;
                wide       = v_old + wide * dt;
                v_new      = clamp64(wide);
                vel_acc[i] = v_new[dimu_pkg::ACC_W-1:0];
                // position from old and new velocity
                wide       = v_old + v_new;
                wide       = clamp64(wide) * dt;
                pos_step   = clamp64(wide);
                wide       = pos_acc[i] + pos_step;
                pos_acc[i] = clamp64(wide);
                last_acc_pair[i]  = acc_pair;
                last_gyro_pair[i] = gyro_pair;
            end
            nav.rotation_x = rot_acc[0];
            nav.rotation_y = rot_acc[1];
            nav.rotation_z = rot_acc[2];
            nav.velocity_x = vel_acc[0];
            nav.velocity_y = vel_acc[1];
            nav.velocity_z = vel_acc[2];
            nav.position_x = pos_acc[0];
            nav.position_y = pos_acc[1];
            nav.position_z = pos_acc[2];
            nav_expected.push_back(nav);
        end
    endtask

    function automatic string field_name(input int f);
        case (f)
            0: return "rotation_x";
            1: return "rotation_y";
            2: return "rotation_z";
            3: return "velocity_x";
            4: return "velocity_y";
            5: return "velocity_z";
            6: return "position_x";
            7: return "position_y";
            default: return "position_z";
        endcase
    endfunction

    // sample with extra weight on the extremes and zero
    function automatic logic [dimu_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [dimu_pkg::INTERVAL_BITS-1:0] pick_interval();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic dimu_pkg::t_in_beat rand_beat(input bit id);
        dimu_pkg::t_in_beat b;
        b.sensor_id   = id;
        b.accel_x     = pick_sample();
        b.accel_y     = pick_sample();
        b.accel_z     = pick_sample();
        b.rate_x      = pick_sample();
        b.rate_y      = pick_sample();
        b.rate_z      = pick_sample();
        b.interval_us = pick_interval();
        return b;
    endfunction

    // same value on all three axes
    function automatic dimu_pkg::t_in_beat make_beat(input bit id,
                                                     input logic [15:0] acc,
                                                     input logic [15:0] gyro,
                                                     input logic [15:0] dt);
        return {id, acc, acc, acc, gyro, gyro, gyro, dt};
    endfunction

    // mostly well-formed A then B pairs, some lone and repeated readings
    task automatic add_random_items(input int count);
        int added;
        added = 0;
        while (added < count) begin
            case ($urandom_range(0, 19))
                17: begin
                    imu_beats_pending.push_back(rand_beat(1'b0));
                    imu_beats_pending.push_back(rand_beat(1'b0));
                    imu_beats_pending.push_back(rand_beat(1'b1));
                    added += 3;
                end
                18: begin
                    imu_beats_pending.push_back(rand_beat(1'b1));
                    added += 1;
                end
                19: begin
                    imu_beats_pending.push_back(rand_beat(1'b0));
                    added += 1;
                end
                default: begin
                    imu_beats_pending.push_back(rand_beat(1'b0));
                    imu_beats_pending.push_back(rand_beat(1'b1));
                    added += 2;
                end
            endcase
        end
    endtask

    task automatic wait_beats_sent();
        do @(posedge i_clk); while (imu_beats_pending.size() != 0);
    endtask

    // wait for every result, then let the block finish any seeding beat
    task automatic wait_nav_idle();
        do @(posedge i_clk);
        while (imu_beats_pending.size() != 0 || i_in_valid || nav_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [dimu_pkg::CFG_IDX_W-1:0] idx,
                                input logic [dimu_pkg::SAMPLE_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            dimu_pkg::CFG_OFFSET_X: bias[0] = value;
            dimu_pkg::CFG_OFFSET_Y: bias[1] = value;
            dimu_pkg::CFG_OFFSET_Z: bias[2] = value;
            default: ;
        endcase
    endtask

    // input beat driver
    always @(negedge i_clk) begin : beat_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else if (!i_in_valid || in_fire_q) begin
            if (send_gap == 0 && idle_on && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 6);
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (imu_beats_pending.size() != 0) begin
                i_in_data  <= imu_beats_pending.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin : result_stall
        if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 6);
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // check result beats, then feed accepted input beats to the predictor
    always @(posedge i_clk) begin : nav_monitor
        dimu_pkg::t_out_beat want;
        logic [63:0]         want_f, got_f;
        in_fire_q <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (nav_expected.size() == 0) begin
                    nav_mismatches++;
                    if (nav_mismatches <= MAX_REPORTS)
                        $display("result beat arrived with none outstanding");
                end else begin
                    want = nav_expected.pop_front();
                    for (int f = 0; f < NAV_FIELDS; f++) begin
                        want_f = want[(NAV_FIELDS-1-f)*dimu_pkg::ACC_W +: dimu_pkg::ACC_W];
                        got_f  = o_out_data[(NAV_FIELDS-1-f)*dimu_pkg::ACC_W +: dimu_pkg::ACC_W];
                        if (got_f !== want_f) begin
                            nav_mismatches++;
                            if (nav_mismatches <= MAX_REPORTS)
                                $display("%s mismatch: expected %0d got %0d",
                                         field_name(f), $signed(want_f), $signed(got_f));
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready)
                integrate_beat(i_in_data);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lone B after reset seeds from zero held readings
        imu_beats_pending.push_back(make_beat(1'b1, 16'h7FFF, 16'h8000, 16'h1234));
        // full-scale pair, interval on the A beat is ignored
        imu_beats_pending.push_back(make_beat(1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        imu_beats_pending.push_back(make_beat(1'b1, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        // repeated A, the second replaces the first; zero interval
        imu_beats_pending.push_back(make_beat(1'b0, 16'h0001, 16'h0001, 16'h0000));
        imu_beats_pending.push_back(make_beat(1'b0, 16'h8000, 16'h8000, 16'h0000));
        imu_beats_pending.push_back(make_beat(1'b1, 16'h8000, 16'h8000, 16'h0000));
        // B with no new A reuses the held reading
        imu_beats_pending.push_back(make_beat(1'b1, 16'h0000, 16'h0000, 16'h0001));
        imu_beats_pending.push_back(make_beat(1'b0, 16'hFFFF, 16'h0001, 16'h5555));
        imu_beats_pending.push_back(make_beat(1'b1, 16'h0001, 16'hFFFF, 16'hFFFF));
        imu_beats_pending.push_back(rand_beat(1'b0));
        imu_beats_pending.push_back(make_beat(1'b1, 16'h7FFF, 16'h8000, 16'h8000));
        imu_beats_pending.push_back(make_beat(1'b1, 16'h0000, 16'h0000, 16'h0000));
        imu_beats_pending.push_back(rand_beat(1'b0));
        imu_beats_pending.push_back(rand_beat(1'b1));
        wait_nav_idle();

        // extreme offsets, then random traffic
        write_offset(dimu_pkg::CFG_OFFSET_X, 16'h8000);
        write_offset(dimu_pkg::CFG_OFFSET_Y, 16'h7FFF);
        write_offset(dimu_pkg::CFG_OFFSET_Z, 16'hFFFF);
        write_offset(CFG_SPARE, 16'($urandom));
        add_random_items(40);
        wait_nav_idle();

        // drive position up into positive saturation
        write_offset(dimu_pkg::CFG_OFFSET_X, 16'h8000);
        write_offset(dimu_pkg::CFG_OFFSET_Y, 16'h8000);
        write_offset(dimu_pkg::CFG_OFFSET_Z, 16'h8000);
        for (int k = 0; k < 100; k++) begin
            imu_beats_pending.push_back(make_beat(1'b0, 16'h7FFF, pick_sample(), 16'hFFFF));
            imu_beats_pending.push_back(make_beat(1'b1, 16'h7FFF, pick_sample(), 16'hFFFF));
        end
        wait_nav_idle();

        // and back down through to negative saturation
        write_offset(dimu_pkg::CFG_OFFSET_X, 16'h7FFF);
        write_offset(dimu_pkg::CFG_OFFSET_Y, 16'h7FFF);
        write_offset(dimu_pkg::CFG_OFFSET_Z, 16'h7FFF);
        for (int k = 0; k < 240; k++) begin
            imu_beats_pending.push_back(make_beat(1'b0, 16'h8000, pick_sample(), 16'hFFFF));
            imu_beats_pending.push_back(make_beat(1'b1, 16'h8000, pick_sample(), 16'hFFFF));
        end
        wait_nav_idle();

        // random offsets and traffic, the tail without any idling
        write_offset(dimu_pkg::CFG_OFFSET_X, pick_sample());
        write_offset(dimu_pkg::CFG_OFFSET_Y, pick_sample());
        write_offset(dimu_pkg::CFG_OFFSET_Z, pick_sample());
        write_offset(CFG_SPARE, 16'($urandom));
        add_random_items(50);
        wait_beats_sent();
        idle_on = 1'b0;
        add_random_items(30);
        wait_nav_idle();

        if (nav_mismatches == 0 && nav_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/dimu_pkg.sv
design/dimu_ctrl.sv
design/dimu_dpath.sv
design/dual_imu_trapezoid_integrator_top.sv
sim/dual_imu_trapezoid_integrator_top_tb.sv
